FILE: hw/rtl/arx_third_order_plant_step_unit_assert.svh
// Assertion macros shared by the plant step RTL.
`ifndef ARX_THIRD_ORDER_PLANT_STEP_UNIT_ASSERT_SVH
`define ARX_THIRD_ORDER_PLANT_STEP_UNIT_ASSERT_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define ARX_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed in %m");

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define ARX_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed in %m");

`endif

FILE: hw/rtl/arxps_pkg.sv
// Types, constants and arithmetic helpers for the ARX plant step unit.
`timescale 1ns / 1ps

package arxps_pkg;

  localparam int SAMPLE_W  = 32;
  localparam int COEF_W    = 20;
  localparam int DELAY_W   = 4;
  localparam int NUM_TAPS  = 3;
  localparam int FRAC_W    = 16;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int RND_W     = PROD_W - FRAC_W;
  localparam int ACC_W     = RND_W + 4;
  localparam int CFG_W     = 20;
  localparam int REG_IDX_W = 3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [RND_W-1:0]    term_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  localparam acc_t  ACC_MAX    = ACC_W'(32'sh7FFF_FFFF);
  localparam acc_t  ACC_MIN    = ACC_W'(32'sh8000_0000);
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1 << (FRAC_W - 1));

  // Configuration register indexes.
  typedef enum logic [REG_IDX_W-1:0] {
    REG_COEF_A1     = 3'd0,
    REG_COEF_A2     = 3'd1,
    REG_COEF_A3     = 3'd2,
    REG_COEF_B1     = 3'd3,
    REG_COEF_B2     = 3'd4,
    REG_COEF_B3     = 3'd5,
    REG_INPUT_DELAY = 3'd6
  } reg_index_t;

  // Which terms of the difference equation take part in this step.
  typedef struct packed {
    logic                active;
    logic [NUM_TAPS-1:0] term_en;
  } tap_ctl_t;

  // Q16.16 sample times Q4.16 coefficient, rounded half up to Q20.16.
  function automatic term_t mul_round(input sample_t smp, input coef_t coef);
    logic signed [PROD_W-1:0] prod;
    prod = PROD_W'(smp) * PROD_W'(coef);
    prod = prod + ROUND_HALF;
    return prod[PROD_W-1:FRAC_W];
  endfunction

endpackage

FILE: hw/rtl/arxps_if.sv
// Valid/ready channel interfaces for plant step transactions and results.
`timescale 1ns / 1ps

interface arxps_in_if import arxps_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t drive_sample;
  sample_t disturbance;

  modport source (output valid, output drive_sample, output disturbance, input ready);
  modport sink (input valid, input drive_sample, input disturbance, output ready);
endinterface

interface arxps_out_if import arxps_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t plant_output;

  modport source (output valid, output plant_output, input ready);
  modport sink (input valid, input plant_output, output ready);
endinterface

FILE: hw/rtl/arxps_sum.sv
// Combinational multiply, round, accumulate and saturate for one plant step.
`timescale 1ns / 1ps

module arxps_sum import arxps_pkg::*; (
  input  tap_ctl_t ctl,
  input  sample_t  disturbance,
  input  sample_t  u_tap [NUM_TAPS],
  input  sample_t  y_tap [NUM_TAPS],
  input  coef_t    coef_a [NUM_TAPS],
  input  coef_t    coef_b [NUM_TAPS],
  output sample_t  y
);

  acc_t acc;

  // Six products in parallel, summed with the disturbance, then clipped to 32 bits.
  always_comb begin
    acc = ACC_W'(disturbance);
    for (int k = 0; k < NUM_TAPS; k++) begin
      if (ctl.term_en[k]) begin
        acc = acc + ACC_W'(mul_round(u_tap[k], coef_b[k]))
                  - ACC_W'(mul_round(y_tap[k], coef_a[k]));
      end
    end
    // During warm-up the output is zero and the disturbance is not applied.
    if (!ctl.active) begin
      acc = '0;
    end
    if (acc > ACC_MAX) begin
      y = ACC_MAX[SAMPLE_W-1:0];
    end else if (acc < ACC_MIN) begin
      y = ACC_MIN[SAMPLE_W-1:0];
    end else begin
      y = acc[SAMPLE_W-1:0];
    end
  end

endmodule

FILE: hw/rtl/arx_third_order_plant_step_unit.sv
// Third-order ARX plant step unit with configurable input transport delay.
//
// Usage: each transaction on the step channel carries one drive sample u and
// one disturbance z (both signed Q16.16); every transaction produces exactly
// one saturated plant output y on the result channel, in order.
// Coefficients (signed Q4.16) and the input delay are written through the
// cfg_we / cfg_index / cfg_wdata port while no step is in flight.
// An accepted transaction is registered in the input register; its output is
// computed from there and registered in the result register, which presents
// it on the result channel. Throughput is one transaction per cycle while the
// result channel does not stall; the output feedback loop closes through the
// output history registers, six parallel multipliers and one adder tree.
// A stalled receiver holds the result register; the input register still
// takes one more transaction, after which step.ready drops until the result
// is taken.
// Reset (rst, synchronous) clears the sample count, the coefficients and the
// delay, and empties both pipeline registers. History contents are only read
// after they have been written, so they need no reset.
`timescale 1ns / 1ps
`include "arx_third_order_plant_step_unit_assert.svh"

module arx_third_order_plant_step_unit import arxps_pkg::*; #(
  parameter int MAX_DELAY = 15
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  arxps_in_if.sink             step,
  arxps_out_if.source          result
);

  localparam int HIST_DEPTH = MAX_DELAY + NUM_TAPS;
  localparam int CNT_W      = $clog2(HIST_DEPTH + 1);
  localparam int IDX_W      = $clog2(HIST_DEPTH);
  localparam int WIDE_W     = ((CNT_W > DELAY_W) ? CNT_W : DELAY_W) + 1;
  localparam logic [CNT_W-1:0]  SEEN_MAX  = CNT_W'(HIST_DEPTH);
  localparam logic [WIDE_W-1:0] DELAY_MAX = WIDE_W'(MAX_DELAY);

  // Configuration registers.
  coef_t              coef_a [NUM_TAPS];
  coef_t              coef_b [NUM_TAPS];
  logic [DELAY_W-1:0] input_delay;

  // Pipeline registers.
  logic    s1_valid;
  sample_t s1_u;
  sample_t s1_z;
  logic    s1_advance;
  logic    res_valid;
  sample_t res_y;

  // History and warm-up count.
  sample_t          u_hist [HIST_DEPTH];
  sample_t          y_hist [NUM_TAPS];
  logic [CNT_W-1:0] samples_seen;
  logic [CNT_W-1:0] samples_seen_next;

  // Tap selection and step result.
  logic [WIDE_W-1:0] d_wide;
  logic [IDX_W-1:0]  d_idx;
  sample_t           u_tap [NUM_TAPS];
  tap_ctl_t          ctl;
  sample_t           y_calc;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_TAPS; k++) begin
        coef_a[k] <= '0;
        coef_b[k] <= '0;
      end
      input_delay <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COEF_A1:     coef_a[0] <= cfg_wdata;
        REG_COEF_A2:     coef_a[1] <= cfg_wdata;
        REG_COEF_A3:     coef_a[2] <= cfg_wdata;
        REG_COEF_B1:     coef_b[0] <= cfg_wdata;
        REG_COEF_B2:     coef_b[1] <= cfg_wdata;
        REG_COEF_B3:     coef_b[2] <= cfg_wdata;
        REG_INPUT_DELAY: input_delay <= cfg_wdata[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the input register moves on when the result register is free.
  assign s1_advance   = s1_valid && (!res_valid || result.ready);
  assign step.ready   = !s1_valid || s1_advance;
  assign result.valid = res_valid;
  assign result.plant_output = res_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (step.ready) begin
      s1_valid <= step.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step.valid && step.ready) begin
      s1_u <= step.drive_sample;
      s1_z <= step.disturbance;
    end
  end

  // Effective delay, clamped to the history that exists.
  always_comb begin
    d_wide = WIDE_W'(input_delay);
    if (d_wide > DELAY_MAX) begin
      d_wide = DELAY_MAX;
    end
    d_idx = d_wide[IDX_W-1:0];
  end

  // Tap selection from the input delay line and the term enables.
  always_comb begin
    for (int k = 0; k < NUM_TAPS; k++) begin
      u_tap[k] = u_hist[d_idx + IDX_W'(k)];
      ctl.term_en[k] = WIDE_W'(samples_seen) >= d_wide + WIDE_W'(k + 1);
    end
    ctl.active = ctl.term_en[0];
  end

  arxps_sum u_sum (
    .ctl         (ctl),
    .disturbance (s1_z),
    .u_tap       (u_tap),
    .y_tap       (y_hist),
    .coef_a      (coef_a),
    .coef_b      (coef_b),
    .y           (y_calc)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_advance) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      res_y <= y_calc;
    end
  end

  // History shift lines advance once per completed step.
  always_ff @(posedge clk) begin
    if (s1_advance) begin
      u_hist[0] <= s1_u;
      for (int i = 1; i < HIST_DEPTH; i++) begin
        u_hist[i] <= u_hist[i-1];
      end
      y_hist[0] <= y_calc;
      for (int i = 1; i < NUM_TAPS; i++) begin
        y_hist[i] <= y_hist[i-1];
      end
    end
  end

  // Saturating sample count.
  always_comb begin
    samples_seen_next = samples_seen;
    if (s1_advance && (samples_seen < SEEN_MAX)) begin
      samples_seen_next = samples_seen + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_seen <= '0;
    end else begin
      samples_seen <= samples_seen_next;
    end
  end

  // Checks on pipeline and history behavior.
  `ARX_ASSERT_NEXT(a_result_follows_step, s1_advance, res_valid)
  `ARX_ASSERT_NEXT(a_warmup_zero, (s1_advance && !ctl.active), (res_y == '0))
  `ARX_ASSERT_NEXT(a_feedback_matches_result, s1_advance, (y_hist[0] == res_y))
  `ARX_ASSERT_NEXT(a_count_steps, (s1_advance && (samples_seen < SEEN_MAX)), (samples_seen == $past(samples_seen) + CNT_W'(1)))

endmodule
